// ----- src/node_liveness_table_core_macros.svh -----
// Assertion macros for the node liveness table core and its checker.
// Depends on nothing; the using scope must provide aclk and aresetn.
`ifndef NODE_LIVENESS_TABLE_CORE_MACROS_SVH
`define NODE_LIVENESS_TABLE_CORE_MACROS_SVH

// Property checked outside reset only.
`define NLT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define NLT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/nlt_pkg.sv -----
// Shared types and constants of the node liveness table core.
// Used by the controller, the datapath, the top level and the checker.
package nlt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] CMD_JOIN      = 2'd0;
    localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;

    localparam logic [1:0] EV_ONLINE  = 2'd0;
    localparam logic [1:0] EV_OFFLINE = 2'd1;
    localparam logic [1:0] EV_FULL    = 2'd2;

    localparam logic [7:0] LIMIT_RESET = 8'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] node_addr;
        logic [7:0]  node_type;
        logic [7:0]  led_status;
    } in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] report_addr;
        logic [7:0]  report_type;
        logic [7:0]  report_status;
        logic        last;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // capture request, clear search flags and expiry mask
        logic scan_step;  // examine the slot under the index, then advance
        logic commit_join;
        logic commit_hb;
        logic emit_join;
        logic emit_off;   // report the slot under the index offline, advance
        logic skip;       // advance the index only
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_cmd;
        logic       idx_last;
        logic       mask_any;
        logic       mask_bit;
        logic       mask_rest_empty;
        logic       out_free;
    } ctrl_stat_t;

endpackage

// ----- src/nlt_datapath.sv -----
// Datapath of the node liveness table: slot storage, scan index, search flags,
// expiry mask and the result register. Depends on nlt_pkg.
module nlt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  nlt_pkg::in_t        s_data,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_heartbeat_limit,
    input  logic                m_ready,
    output logic                m_valid,
    output nlt_pkg::out_t       m_data,
    input  nlt_pkg::ctrl_cmd_t  cmd,
    output nlt_pkg::ctrl_stat_t stat
);

    localparam int DEPTH = nlt_pkg::TABLE_DEPTH;
    localparam int IW    = nlt_pkg::IDX_W;

    nlt_pkg::in_t           req_reg;
    logic [7:0]             limit_reg;
    logic [IW-1:0]          idx_reg;
    logic                   hit_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic                   free_reg;
    logic [IW-1:0]          free_idx_reg;
    logic [DEPTH-1:0]       mask_reg;
    logic [DEPTH-1:0]       valid_reg;
    logic                   m_valid_reg;
    nlt_pkg::out_t          m_data_reg;

    logic [15:0]            addr_mem [DEPTH];
    logic [7:0]             cnt_mem  [DEPTH];
    logic [7:0]             type_mem [DEPTH];
    logic [7:0]             stat_mem [DEPTH];

    logic                   idx_last;
    logic [IW-1:0]          idx_inc;
    logic [7:0]             cnt_dec;
    logic                   addr_eq;
    logic [DEPTH-1:0]       mask_rest;
    logic                   placed;
    logic [IW-1:0]          tgt_idx;
    logic                   out_free;
    logic                   advance;

    assign idx_last = (idx_reg == IW'(DEPTH - 1));
    assign idx_inc  = idx_last ? '0 : idx_reg + IW'(1);
    assign advance  = cmd.scan_step | cmd.emit_off | cmd.skip;

    // Saturating decrement of the slot under the index.
    assign cnt_dec  = (cnt_mem[idx_reg] == 8'd0) ? 8'd0 : cnt_mem[idx_reg] - 8'd1;
    assign addr_eq  = valid_reg[idx_reg] && (addr_mem[idx_reg] == req_reg.node_addr);

    always_comb begin
        mask_rest          = mask_reg;
        mask_rest[idx_reg] = 1'b0;
    end

    assign placed   = hit_reg | free_reg;
    assign tgt_idx  = hit_reg ? hit_idx_reg : free_idx_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= nlt_pkg::LIMIT_RESET;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            mask_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_heartbeat_limit;
            end
            if (cmd.load_req) begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                mask_reg <= '0;
            end else if (advance) begin
                idx_reg <= idx_inc;
            end
            if (cmd.scan_step) begin
                if (req_reg.command == nlt_pkg::CMD_TICK) begin
                    // Free the slot as soon as its counter runs out.
                    if (valid_reg[idx_reg] && cnt_dec == 8'd0) begin
                        valid_reg[idx_reg] <= 1'b0;
                        mask_reg[idx_reg]  <= 1'b1;
                    end
                end else begin
                    if (addr_eq && !hit_reg) begin
                        hit_reg <= 1'b1;
                    end
                    if (!valid_reg[idx_reg] && !free_reg) begin
                        free_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit_join && placed) begin
                valid_reg[tgt_idx] <= 1'b1;
            end
            if (cmd.emit_off) begin
                mask_reg[idx_reg] <= 1'b0;
            end
            if (cmd.emit_join || cmd.emit_off) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: request, slot contents, captured indexes and result data.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
        if (cmd.scan_step) begin
            if (req_reg.command == nlt_pkg::CMD_TICK) begin
                if (valid_reg[idx_reg]) begin
                    cnt_mem[idx_reg] <= cnt_dec;
                end
            end else begin
                if (addr_eq && !hit_reg) begin
                    hit_idx_reg <= idx_reg;
                end
                if (!valid_reg[idx_reg] && !free_reg) begin
                    free_idx_reg <= idx_reg;
                end
            end
        end
        if (cmd.commit_join && placed) begin
            addr_mem[tgt_idx] <= req_reg.node_addr;
            type_mem[tgt_idx] <= req_reg.node_type;
            stat_mem[tgt_idx] <= req_reg.led_status;
            cnt_mem[tgt_idx]  <= limit_reg;
        end
        if (cmd.commit_hb && hit_reg) begin
            cnt_mem[hit_idx_reg] <= limit_reg;
        end
        if (cmd.emit_join) begin
            m_data_reg.event_res     <= placed ? nlt_pkg::EV_ONLINE : nlt_pkg::EV_FULL;
            m_data_reg.report_addr   <= req_reg.node_addr;
            m_data_reg.report_type   <= req_reg.node_type;
            m_data_reg.report_status <= req_reg.led_status;
            m_data_reg.last          <= 1'b1;
        end else if (cmd.emit_off) begin
            m_data_reg.event_res     <= nlt_pkg::EV_OFFLINE;
            m_data_reg.report_addr   <= addr_mem[idx_reg];
            m_data_reg.report_type   <= type_mem[idx_reg];
            m_data_reg.report_status <= stat_mem[idx_reg];
            m_data_reg.last          <= (mask_rest == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.req_cmd         = req_reg.command;
    assign stat.idx_last        = idx_last;
    assign stat.mask_any        = (mask_reg != '0);
    assign stat.mask_bit        = mask_reg[idx_reg];
    assign stat.mask_rest_empty = (mask_rest == '0);
    assign stat.out_free        = out_free;

endmodule

// ----- src/nlt_ctrl.sv -----
// Controller of the node liveness table: sequences the slot scan, the commit
// and the offline walk. Depends on nlt_pkg.
module nlt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output nlt_pkg::ctrl_cmd_t  cmd,
    input  nlt_pkg::ctrl_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.idx_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                case (stat.req_cmd)
                    nlt_pkg::CMD_JOIN: begin
                        // Hold until the result register can take the report.
                        if (stat.out_free) begin
                            cmd.commit_join = 1'b1;
                            cmd.emit_join   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    nlt_pkg::CMD_HEARTBEAT: begin
                        cmd.commit_hb = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    nlt_pkg::CMD_TICK: begin
                        state_next = stat.mask_any ? ST_WALK : ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK: begin
                if (!stat.mask_bit) begin
                    cmd.skip = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit_off = 1'b1;
                    if (stat.mask_rest_empty) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- src/node_liveness_table_core.sv -----
// Node liveness table core: a table of TABLE_DEPTH node slots scanned one slot
// per clock. Every request is accepted and then scanned over all slots, and
// the next request is taken only once its handling is done. A join finishes
// once the output register can take its result; a heartbeat gives no result.
// A tick takes the same scan, then walks the slots again in ascending order up
// to the last expired node and reports each expired node; the walk halts on a
// report that the full output register cannot take until m_ready frees it. A
// finished result waits in the output register while the next request is
// taken. The heartbeat limit may be written only while idle.
module node_liveness_table_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  nlt_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output nlt_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_heartbeat_limit
);

    nlt_pkg::ctrl_cmd_t  cmd;
    nlt_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    nlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    nlt_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_data              (s_data),
        .cfg_valid           (cfg_valid),
        .cfg_heartbeat_limit (cfg_heartbeat_limit),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_data              (m_data),
        .cmd                 (cmd),
        .stat                (stat)
    );

endmodule

// ----- src/nlt_checker.sv -----
// Port checker for the node liveness table core, bound to the top level.
// Depends on nlt_pkg and node_liveness_table_core_macros.svh.
`include "node_liveness_table_core_macros.svh"

module nlt_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input nlt_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input nlt_pkg::out_t m_data
);

    logic join_report;

    assign join_report = m_valid && (m_data.event_res != nlt_pkg::EV_OFFLINE);

    // A stalled result holds.
    `NLT_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result not held")

    // No result comes out of reset.
    `NLT_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "result valid after reset")

    // Every request is scanned, so the block is busy the cycle after taking one.
    `NLT_ASSERT(a_busy_after_req, s_valid && s_ready |=> !s_ready, "request taken without scan")

    // Online and refused reports are single results of a join.
    `NLT_ASSERT(a_join_last, join_report |-> m_data.last, "join report not flagged last")

endmodule

bind node_liveness_table_core nlt_checker u_nlt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/tb_node_liveness_table_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for node_liveness_table_core: sends join, heartbeat and tick
// requests, keeps its own copy of the slot table and checks every report in order.
// Depends on nlt_pkg and the core RTL.
module tb_node_liveness_table_core;
    import nlt_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         POOL_SIZE     = 24;
    localparam int         PHASE_ITEMS   = 67;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_heartbeat_limit;

    // Own copy of the slot table and the heartbeat limit.
    logic        slot_used   [TABLE_DEPTH];
    logic [15:0] slot_addr   [TABLE_DEPTH];
    logic [7:0]  slot_life   [TABLE_DEPTH];
    logic [7:0]  slot_type   [TABLE_DEPTH];
    logic [7:0]  slot_status [TABLE_DEPTH];
    logic [7:0]  live_limit;

    out_t        expected_reports[$];
    int          error_count = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    bit          hold_start  = 1'b0;
    logic [15:0] addr_pool[POOL_SIZE];

    node_liveness_table_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data             (s_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_heartbeat_limit(cfg_heartbeat_limit)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int find_node(logic [15:0] addr);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_addr[i] == addr) return i;
        end
        return -1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!slot_used[i]) return i;
        end
        return -1;
    endfunction

    // Apply one request to the table copy and queue the reports it causes.
    function automatic void predict_request(in_t req);
        int   idx;
        out_t rep;
        out_t pending;
        bit   have_pending;
        have_pending = 1'b0;
        case (req.command)
            CMD_JOIN: begin
                idx = find_node(req.node_addr);
                if (idx < 0) idx = find_free_slot();
                if (idx >= 0) begin
                    slot_used[idx]   = 1'b1;
                    slot_addr[idx]   = req.node_addr;
                    slot_type[idx]   = req.node_type;
                    slot_status[idx] = req.led_status;
                    slot_life[idx]   = live_limit;
                end
                rep.event_res     = (idx < 0) ? EV_FULL : EV_ONLINE;
                rep.report_addr   = req.node_addr;
                rep.report_type   = req.node_type;
                rep.report_status = req.led_status;
                rep.last          = 1'b1;
                expected_reports.push_back(rep);
            end
            CMD_HEARTBEAT: begin
                idx = find_node(req.node_addr);
                if (idx >= 0) slot_life[idx] = live_limit;
            end
            CMD_TICK: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        // saturate at zero, so a zero limit expires on the next tick
                        if (slot_life[i] != 8'd0) slot_life[i] = slot_life[i] - 8'd1;
                        if (slot_life[i] == 8'd0) begin
                            slot_used[i] = 1'b0;
                            if (have_pending) expected_reports.push_back(pending);
                            pending.event_res     = EV_OFFLINE;
                            pending.report_addr   = slot_addr[i];
                            pending.report_type   = slot_type[i];
                            pending.report_status = slot_status[i];
                            pending.last          = 1'b0;
                            have_pending          = 1'b1;
                        end
                    end
                end
                if (have_pending) begin
                    pending.last = 1'b1;
                    expected_reports.push_back(pending);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_t make_req(logic [1:0] cmd, logic [15:0] addr,
                                     logic [7:0] typ, logic [7:0] st);
        in_t req;
        req.command    = cmd;
        req.node_addr  = addr;
        req.node_type  = typ;
        req.led_status = st;
        return req;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 20);
        return $urandom_range(0, 2);
    endfunction

    function automatic in_t random_request(int join_weight);
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < join_weight)      cmd = CMD_JOIN;
        else if (pick < 66)          cmd = CMD_HEARTBEAT;
        else if (pick < 95)          cmd = CMD_TICK;
        else                         cmd = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) addr = 16'($urandom);
        else                           addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return make_req(cmd, addr, 8'($urandom), 8'($urandom));
    endfunction

    // Called at a falling edge; returns at a falling edge with s_valid possibly
    // still high, so the next request can follow without a gap.
    task automatic send_request(in_t req);
        int gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_request(req);
        @(negedge aclk);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drop valid, wait for every report, then let a request that gives no report finish its scan.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(logic [7:0] value);
        wait_idle();
        cfg_valid           <= 1'b1;
        cfg_heartbeat_limit <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        live_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset limit: joins at the field extremes, refresh of a known node, an unknown
    // heartbeat, the unused command, and ticks until both nodes go offline together.
    task automatic test_basic_commands();
        send_request(make_req(CMD_JOIN, 16'h0000, 8'h00, 8'hFF));
        send_request(make_req(CMD_JOIN, 16'hFFFF, 8'hFF, 8'h00));
        send_request(make_req(CMD_JOIN, 16'h0000, 8'hA5, 8'h5A));
        send_request(make_req(CMD_HEARTBEAT, 16'h1234, 8'hFF, 8'hFF));
        send_request(make_req(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF));
        send_request(make_req(CMD_HEARTBEAT, 16'hFFFF, 8'h00, 8'h00));
        repeat (3) send_request(make_req(CMD_TICK, 16'h0000, 8'h00, 8'h00));
    endtask

    // Zero limit: fill every slot, refuse a new node, refresh a known one while full,
    // then one tick frees the whole table in slot order.
    task automatic test_full_table();
        write_limit(8'd0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(make_req(CMD_JOIN, addr_pool[i], 8'($urandom), 8'($urandom)));
        send_request(make_req(CMD_JOIN, addr_pool[TABLE_DEPTH], 8'hC3, 8'h3C));
        send_request(make_req(CMD_JOIN, addr_pool[3], 8'h7E, 8'h81));
        send_request(make_req(CMD_TICK, 16'h0000, 8'h00, 8'h00));
    endtask

    task automatic test_limit_maximum();
        write_limit(8'd255);
        send_request(make_req(CMD_JOIN, addr_pool[5], 8'h11, 8'h22));
        send_request(make_req(CMD_TICK, 16'h0000, 8'h00, 8'h00));
    endtask

    // Hold the receiver off while joins keep coming, so the core stalls its input.
    task automatic test_backpressure();
        write_limit(8'd4);
        hold_start = 1'b1;
        repeat (10) send_request(random_request(90));
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [7:0] phase_limit[6] = '{8'd1, 8'd20, 8'd255, 8'd0, 8'd5, 8'd3};
        int         sent;
        in_t        req;
        foreach (phase_limit[p]) begin
            write_limit(phase_limit[p]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                req = random_request(38);
                send_request(req);
                if (req.command != CMD_UNUSED) sent++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin : receiver
        int stall;
        int hold;
        m_ready = 1'b0;
        stall   = 0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold       = HOLD_CYCLES;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : report_check
        out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report ev=%0d addr=%h type=%h status=%h last=%b",
                         $time, m_data.event_res, m_data.report_addr,
                         m_data.report_type, m_data.report_status, m_data.last);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                if (m_data.event_res !== want.event_res
                        || m_data.report_addr !== want.report_addr
                        || m_data.report_type !== want.report_type
                        || m_data.report_status !== want.report_status
                        || m_data.last !== want.last) begin
                    $display("%0t: report mismatch expected ev=%0d addr=%h type=%h status=%h last=%b",
                             $time, want.event_res, want.report_addr, want.report_type,
                             want.report_status, want.last);
                    $display("%0t:                 actual ev=%0d addr=%h type=%h status=%h last=%b",
                             $time, m_data.event_res, m_data.report_addr, m_data.report_type,
                             m_data.report_status, m_data.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        s_valid             = 1'b0;
        s_data              = '0;
        cfg_valid           = 1'b0;
        cfg_heartbeat_limit = LIMIT_RESET;
        aresetn             = 1'b0;
        live_limit          = LIMIT_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = 16'($urandom);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_commands();
        test_full_table();
        test_limit_maximum();
        test_backpressure();
        test_random_phases();
        wait_idle();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- node_liveness_table_core.f -----
+incdir+src
src/nlt_pkg.sv
src/nlt_datapath.sv
src/nlt_ctrl.sv
src/node_liveness_table_core.sv
src/nlt_checker.sv
tb/sv/tb_node_liveness_table_core.sv
